// ----- rtl/fdr_pkg.sv -----
// Shared types, codes and saturation helper for the diffused FDN reverb.
`timescale 1ns / 1ps
package fdr_pkg;

	localparam logic signed [23:0] SMAX = 24'sh7FFFFF;
	localparam logic signed [23:0] SMIN = 24'sh800000;

	localparam logic FUNC_PROCESS = 1'b0;
	localparam logic FUNC_LOAD    = 1'b1;

	typedef enum logic [1:0] {
		REG_DRY_GAIN,
		REG_WET_GAIN,
		REG_FEEDBACK_GAIN,
		REG_AVERAGE_MODE
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_DIFF,
		ST_SCALE,
		ST_FBRD,
		ST_CORR,
		ST_FBWR,
		ST_AVGL,
		ST_AVGR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               func;
		logic signed [23:0] left_in;
		logic signed [23:0] right_in;
		logic [5:0]         tap_index;
		logic [12:0]        tap_delay;
		logic               tap_flip;
	} req_t;

	typedef struct packed {
		logic signed [23:0] left_out;
		logic signed [23:0] right_out;
	} rsp_t;

	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] q;
	} div_rsp_t;

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		if (v > 64'(SMAX)) return SMAX;
		if (v < 64'(SMIN)) return SMIN;
		return v[23:0];
	endfunction

endpackage

// ----- rtl/fdr_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module fdr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/fdr_fdiv.sv -----
// Floor division by twice the channel count, by reciprocal multiply and one correction.
`timescale 1ns / 1ps
module fdr_fdiv
	import fdr_pkg::*;
#(
	parameter int CHANNELS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam longint D2   = 2 * CHANNELS;
	localparam longint KC   = ((64'sd1 <<< 30) + D2 - 1) / D2;
	localparam longint BIAS = KC * D2;
	localparam longint MR   = (64'sd1 <<< 32) / D2;
	localparam logic [31:0] D2_C   = 32'(D2);
	localparam logic [31:0] KC_C   = 32'(KC);
	localparam logic [31:0] BIAS_C = 32'(BIAS);
	localparam logic [31:0] MR_C   = 32'(MR);

	logic v_s1, v_s2, v_s3;
	logic [31:0] u_s1, u_s2, q_s2;
	logic signed [31:0] q_s3;
	logic [63:0] prod;
	logic [31:0] back, rem, qc;

	assign prod = {32'd0, u_s1} * {32'd0, MR_C};
	assign back = q_s2 * D2_C;
	assign rem  = u_s2 - back;
	assign qc   = (rem >= D2_C) ? q_s2 + 32'd1 : q_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// bias keeps the dividend positive; remove its quotient at the end
	always_ff @(posedge clk) begin
		u_s1 <= $unsigned(req.num) + BIAS_C;
		u_s2 <= u_s1;
		q_s2 <= prod[63:32];
		q_s3 <= $signed(qc - KC_C);
	end

	assign rsp.done = v_s3;
	assign rsp.q    = q_s3;

endmodule

// ----- rtl/fdn_reverb_diffused.sv -----
// Top level of the diffused feedback-delay-network reverb.
//
// Input channel req (req_valid/req_stall) carries one beat per item: a stereo
// Q1.23 sample pair to process, or a tap load (delay and flip of one tap).
// Output channel rsp (rsp_valid/rsp_stall) returns one stereo beat per item;
// load items return zeros. Gains and mode are to be written on the cfg port
// only while the block is idle; the block itself does not enforce this.
// Items are handled one at a time. A process item walks the diffusion line
// RAM port pair once per channel and stage, then passes the Hadamard result
// through one scaling multiplier channel by channel; average mode adds the
// left and right averaging divides.
// After reset the delay-line RAMs are swept to zero, one word a cycle, with
// req_stall high meanwhile. A finished beat waits in the output register
// while rsp_stall is high; the next item is still taken and processed, but
// its result is held until the register is free, and further items wait.
`timescale 1ns / 1ps
module fdn_reverb_diffused
	import fdr_pkg::*;
#(
	parameter int CHANNELS   = 8,
	parameter int STAGES     = 4,
	parameter int LINE_DEPTH = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int NUM_DIFF   = STAGES * CHANNELS;
	localparam int NUM_TAPS   = (STAGES + 1) * CHANNELS;
	localparam int POS_W      = $clog2(LINE_DEPTH);
	localparam int CH_W       = $clog2(CHANNELS);
	localparam int CNT_W      = $clog2(CHANNELS + 3);
	localparam int STG_W      = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int DIFF_DEPTH = NUM_DIFF * LINE_DEPTH;
	localparam int FB_DEPTH   = CHANNELS * LINE_DEPTH;
	localparam int DIFF_AW    = $clog2(DIFF_DEPTH);
	localparam int FB_AW      = $clog2(FB_DEPTH);
	localparam int TAP_AW     = $clog2(NUM_TAPS);
	localparam int ACC_W      = 24 + $clog2(CHANNELS);
	localparam int PROD_W     = ACC_W + 23;
	localparam longint HS_ARG = (64'sd1 <<< 40) / CHANNELS;
	localparam longint MOD_MR = (64'sd1 <<< 32) / LINE_DEPTH;
	localparam logic [CNT_W-1:0] CNT_CH   = CNT_W'(CHANNELS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHANNELS + 1);
	localparam logic [STG_W-1:0] STG_LAST = STG_W'(STAGES - 1);
	localparam logic [DIFF_AW-1:0] CLR_LAST = DIFF_AW'(DIFF_DEPTH - 1);
	localparam logic [31:0] DEPTH_C = 32'(LINE_DEPTH);
	localparam logic signed [31:0] CH_C = 32'(CHANNELS);

	function automatic longint isqrt_round(input longint xin);
		longint x, r, b;
		x = xin;
		r = 0;
		b = 64'sd1 <<< 62;
		for (int k = 0; k < 32; k++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		if (x > r) r = r + 1;
		return r;
	endfunction

	localparam logic signed [22:0] HSCALE = 23'(isqrt_round(HS_ARG));

	// sign of Hadamard coefficient (row i, column j): 01 plus, 11 minus, 00 none
	function automatic logic [1:0] coef(input int i, input int j);
		int n, a, b, h;
		logic s;
		n = CHANNELS;
		a = i;
		b = j;
		s = 1'b0;
		for (int lv = 0; lv < 5; lv++) begin
			if (n > 1) begin
				h = n >> 1;
				if ((n & 1) == 1 && (a == n - 1 || b == n - 1)) begin
					n = 1;
				end else begin
					if (a >= h && b >= h) s = ~s;
					if (a >= h) a = a - h;
					if (b >= h) b = b - h;
					n = h;
				end
			end
		end
		if (a != b) return 2'b00;
		return s ? 2'b11 : 2'b01;
	endfunction

	function automatic logic [CHANNELS-1:0] row_mask(input int i, input logic neg);
		logic [CHANNELS-1:0] m;
		logic [1:0] c;
		m = '0;
		for (int j = 0; j < CHANNELS; j++) begin
			c = coef(i, j);
			m[j] = neg ? (c == 2'b11) : (c == 2'b01);
		end
		return m;
	endfunction

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [STG_W-1:0] stage_q;
	logic [DIFF_AW-1:0] clr_q;
	logic [POS_W-1:0] head_q;
	logic [15:0] dry_q, wet_q;
	logic [14:0] fbg_q;
	logic avg_q;
	req_t in_q;
	rsp_t rsp_q;
	logic rsp_valid_q, rsp_load;

	logic signed [23:0] buf_q [CHANNELS];
	logic signed [23:0] rd_q  [CHANNELS];
	logic               flip_q [CHANNELS];
	logic signed [ACC_W-1:0] acc_q [CHANNELS];
	logic signed [ACC_W-1:0] sum_q, sl_q, sr_q;
	logic signed [31:0] corr_q;
	logic signed [23:0] res_l_q, res_r_q;
	logic [7:0] modq_q;

	logic v_s1_q, v_s2_q, iss;
	logic [CH_W-1:0] ch, ch_s1_q, ch_s2_q;
	logic signed [PROD_W-1:0] prod_s1_q;
	logic flip_s1_q;
	logic signed [23:0] hh_s1_q, rd_s1_q, buf_s1_q, buf_s2_q;
	logic signed [39:0] pfb_s2_q;
	logic signed [40:0] pdry_s2_q, pwet_s2_q;

	logic diff_we, fb_we, tap_we;
	logic [DIFF_AW-1:0] diff_waddr, diff_raddr;
	logic [FB_AW-1:0] fb_waddr, fb_raddr;
	logic [TAP_AW-1:0] tap_waddr, tap_raddr;
	logic [23:0] diff_wdata, fb_wdata, diff_rdata, fb_rdata;
	logic [POS_W:0] tap_wdata, tap_rdata;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [31:0] tail, red_ext, mod_rem, mod_red, tap_line;
	logic signed [23:0] scale_v, g_v, mix_v, xin_s1;
	logic [7:0] idx8;

	assign ch      = cnt_q[CH_W-1:0];
	assign idx8    = {2'b00, in_q.tap_index};
	assign red_ext = 32'(tap_rdata[POS_W-1:0]);
	assign tail    = (32'(head_q) >= red_ext) ? 32'(head_q) - red_ext
	                                          : 32'(head_q) + DEPTH_C - red_ext;
	assign mod_rem = 32'(in_q.tap_delay) - 32'(modq_q) * DEPTH_C;
	assign mod_red = (mod_rem >= DEPTH_C) ? mod_rem - DEPTH_C : mod_rem;
	assign xin_s1  = ch_s1_q[0] ? in_q.right_in : in_q.left_in;

	assign scale_v = sat24((64'(prod_s1_q) + 64'sd524288) >>> 20);
	assign g_v     = sat24((64'(pfb_s2_q) + 64'sd8192) >>> 14);
	assign mix_v   = sat24((64'(pdry_s2_q) + 64'(pwet_s2_q) + 64'sd8192) >>> 14);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == CLR_LAST) state_d = ST_IDLE;
			ST_IDLE: begin
				if (req_valid) state_d = (req.func == FUNC_LOAD) ? ST_LOAD : ST_DIFF;
			end
			ST_LOAD:  if (cnt_q == CNT_W'(1)) state_d = ST_DONE;
			ST_DIFF:  if (cnt_q == CNT_LAST) state_d = ST_SCALE;
			ST_SCALE: begin
				if (cnt_q == CNT_CH) state_d = (stage_q == STG_LAST) ? ST_FBRD : ST_DIFF;
			end
			ST_FBRD:  if (cnt_q == CNT_LAST) state_d = ST_CORR;
			ST_CORR:  if (div_rsp.done) state_d = ST_FBWR;
			ST_FBWR:  if (cnt_q == CNT_LAST) state_d = avg_q ? ST_AVGL : ST_DONE;
			ST_AVGL:  if (div_rsp.done) state_d = ST_AVGR;
			ST_AVGR:  if (div_rsp.done) state_d = ST_DONE;
			ST_DONE:  if (!rsp_valid_q || !rsp_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and memory ports
	always_comb begin
		req_stall  = (state_q != ST_IDLE);
		iss        = 32'(cnt_q) < 32'(CHANNELS);
		rsp_load   = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
		diff_we    = 1'b0;
		diff_waddr = clr_q;
		diff_wdata = '0;
		diff_raddr = DIFF_AW'(32'(32'(stage_q) * 32'(CHANNELS) + 32'(ch_s1_q)) * DEPTH_C + tail);
		fb_we      = 1'b0;
		fb_waddr   = FB_AW'(32'(ch_s2_q) * DEPTH_C + 32'(head_q));
		fb_wdata   = sat24(64'(buf_s2_q) + 64'(g_v));
		fb_raddr   = FB_AW'(32'(ch_s1_q) * DEPTH_C + tail);
		tap_line   = (state_q == ST_FBRD) ? 32'(NUM_DIFF) + 32'(ch)
		                                  : 32'(stage_q) * 32'(CHANNELS) + 32'(ch);
		tap_raddr  = TAP_AW'(tap_line);
		tap_we     = (state_q == ST_LOAD) && (cnt_q == CNT_W'(1)) &&
		             (32'(idx8) < 32'(NUM_TAPS));
		tap_waddr  = idx8[TAP_AW-1:0];
		tap_wdata  = {in_q.tap_flip, mod_red[POS_W-1:0]};
		div_req.start = 1'b0;
		div_req.num   = (32'(sl_q) <<< 2) + CH_C;
		case (state_q)
			ST_CLEAR: begin
				diff_we  = 1'b1;
				fb_we    = 32'(clr_q) < 32'(FB_DEPTH);
				fb_waddr = clr_q[FB_AW-1:0];
				fb_wdata = '0;
			end
			ST_DIFF: begin
				diff_we    = iss;
				diff_waddr = DIFF_AW'(tap_line * DEPTH_C + 32'(head_q));
				diff_wdata = buf_q[ch];
			end
			ST_CORR: begin
				div_req.start = (cnt_q == '0);
				div_req.num   = CH_C - (32'(sum_q) <<< 2);
			end
			ST_FBWR: fb_we = v_s2_q;
			ST_AVGL: div_req.start = (cnt_q == '0);
			ST_AVGR: begin
				div_req.start = (cnt_q == '0);
				div_req.num   = (32'(sr_q) <<< 2) + CH_C;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			stage_q     <= '0;
			clr_q       <= '0;
			head_q      <= '0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			dry_q       <= 16'd16384;
			wet_q       <= 16'd4096;
			fbg_q       <= 15'd11600;
			avg_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
			if (state_q == ST_CLEAR) clr_q <= clr_q + DIFF_AW'(1);
			if (state_q == ST_IDLE) stage_q <= '0;
			else if (state_q == ST_SCALE && state_d == ST_DIFF) stage_q <= stage_q + STG_W'(1);
			if (state_q == ST_FBWR && cnt_q == CNT_LAST) begin
				head_q <= (32'(head_q) == DEPTH_C - 32'd1) ? '0 : head_q + POS_W'(1);
			end
			v_s1_q <= iss && (state_q == ST_DIFF || state_q == ST_SCALE ||
			                  state_q == ST_FBRD || state_q == ST_FBWR);
			v_s2_q <= v_s1_q;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_DRY_GAIN:      dry_q <= cfg_wdata;
					REG_WET_GAIN:      wet_q <= cfg_wdata;
					REG_FEEDBACK_GAIN: fbg_q <= cfg_wdata[14:0];
					REG_AVERAGE_MODE:  avg_q <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) in_q <= req;
		ch_s1_q <= ch;
		ch_s2_q <= ch_s1_q;
		if (state_q == ST_LOAD && cnt_q == '0) begin
			modq_q <= 8'((64'(in_q.tap_delay) * 64'(MOD_MR)) >> 32);
		end
		if (state_q == ST_LOAD) begin
			res_l_q <= '0;
			res_r_q <= '0;
		end
		// spread the input pair over the channels before the first stage
		if (state_q == ST_IDLE) begin
			for (int c = 0; c < CHANNELS; c++) begin
				buf_q[c] <= c[0] ? req.right_in : req.left_in;
			end
		end
		if (state_q == ST_DIFF && v_s1_q) flip_q[ch_s1_q] <= tap_rdata[POS_W];
		if (state_q == ST_SCALE && iss) begin
			prod_s1_q <= acc_q[ch] * HSCALE;
			flip_s1_q <= flip_q[ch];
		end
		if (state_q == ST_SCALE && v_s1_q) begin
			buf_q[ch_s1_q] <= flip_s1_q ? sat24(-64'(scale_v)) : scale_v;
		end
		if (state_q == ST_FBRD && cnt_q == '0) sum_q <= '0;
		else if (state_q == ST_FBRD && v_s2_q) begin
			rd_q[ch_s2_q] <= $signed(fb_rdata);
			sum_q <= sum_q + ACC_W'($signed(fb_rdata));
		end
		if (state_q == ST_CORR && div_rsp.done) corr_q <= div_rsp.q;
		if (state_q == ST_FBWR && iss) begin
			hh_s1_q  <= sat24(64'(rd_q[ch]) + 64'(corr_q));
			rd_s1_q  <= rd_q[ch];
			buf_s1_q <= buf_q[ch];
		end
		if (state_q == ST_FBWR && v_s1_q) begin
			pfb_s2_q  <= hh_s1_q * $signed({1'b0, fbg_q});
			pdry_s2_q <= xin_s1 * $signed({1'b0, dry_q});
			pwet_s2_q <= rd_s1_q * $signed({1'b0, wet_q});
			buf_s2_q  <= buf_s1_q;
		end
		if (state_q == ST_FBWR && cnt_q == '0) begin
			sl_q <= '0;
			sr_q <= '0;
		end else if (state_q == ST_FBWR && v_s2_q) begin
			if (ch_s2_q[0]) sr_q <= sr_q + ACC_W'(mix_v);
			else sl_q <= sl_q + ACC_W'(mix_v);
			if (32'(ch_s2_q) == 32'd0) res_l_q <= mix_v;
			if (32'(ch_s2_q) == 32'd1) res_r_q <= mix_v;
		end
		if (state_q == ST_AVGL && div_rsp.done) res_l_q <= sat24(64'(div_rsp.q));
		if (state_q == ST_AVGR && div_rsp.done) res_r_q <= sat24(64'(div_rsp.q));
		if (rsp_load) begin
			rsp_q.left_out  <= res_l_q;
			rsp_q.right_out <= res_r_q;
		end
	end

	for (genvar gi = 0; gi < CHANNELS; gi++) begin : g_lane
		localparam logic [CHANNELS-1:0] PM = row_mask(gi, 1'b0);
		localparam logic [CHANNELS-1:0] NM = row_mask(gi, 1'b1);
		// accumulate each tap read, with its sign, into every Hadamard output lane whose coefficient is not zero
		always_ff @(posedge clk) begin
			if (state_q == ST_DIFF && cnt_q == '0) begin
				acc_q[gi] <= '0;
			end else if (state_q == ST_DIFF && v_s2_q) begin
				if (PM[ch_s2_q]) acc_q[gi] <= acc_q[gi] + ACC_W'($signed(diff_rdata));
				else if (NM[ch_s2_q]) acc_q[gi] <= acc_q[gi] - ACC_W'($signed(diff_rdata));
			end
		end
	end

	fdr_ram #(.WIDTH(24), .DEPTH(DIFF_DEPTH)) u_diff_ram (
		.clk(clk), .we(diff_we), .waddr(diff_waddr), .wdata(diff_wdata),
		.raddr(diff_raddr), .rdata(diff_rdata)
	);

	fdr_ram #(.WIDTH(24), .DEPTH(FB_DEPTH)) u_fb_ram (
		.clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
		.raddr(fb_raddr), .rdata(fb_rdata)
	);

	fdr_ram #(.WIDTH(POS_W + 1), .DEPTH(NUM_TAPS)) u_tap_ram (
		.clk(clk), .we(tap_we), .waddr(tap_waddr), .wdata(tap_wdata),
		.raddr(tap_raddr), .rdata(tap_rdata)
	);

	fdr_fdiv #(.CHANNELS(CHANNELS)) u_fdiv (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> ##3 div_rsp.done)
		else $error("divider result not back after three cycles");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && rsp_valid && rsp_stall) |=> $stable(rsp))
		else $error("finished result overwrote a stalled beat");

	a_head_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(head_q) |-> $past(state_q == ST_FBWR))
		else $error("line head moved outside the feedback write pass");

endmodule

// ----- tb/fdn_reverb_diffused_test.sv -----
// Self-checking testbench for the diffused FDN reverb: predicted beats against the block.
`timescale 1ns / 1ps
module fdn_reverb_diffused_test;
	import fdr_pkg::*;

	localparam int NCH      = 8;
	localparam int NSTG     = 4;
	localparam int DEPTH    = 8192;
	localparam int NDIFF    = NSTG * NCH;
	localparam int NTAPS    = (NSTG + 1) * NCH;
	localparam int IDLE_MAX = 1000000;

	class reverb_scoreboard;
		int      dline[NDIFF][DEPTH];
		int      fline[NCH][DEPTH];
		int      tap_off[NTAPS];
		bit      flip[NDIFF];
		int      dhead, fhead;
		longint  dry, wet, fbg, hscale;
		bit      avg;
		rsp_t    expected_q[$];
		int      errors;

		function new();
			longint x, r;
			dry = 16384;
			wet = 4096;
			fbg = 11600;
			avg = 0;
			x = (longint'(1) << 40) / NCH;
			r = longint'($sqrt(real'(x)));
			while ((r + 1) * (r + 1) <= x) r++;
			while (r * r > x) r--;
			if (x - r * r > r) r++;
			hscale = r;
		endfunction

		function longint clip24(longint v);
			if (v > 8388607) return 8388607;
			if (v < -8388608) return -8388608;
			return v;
		endfunction

		function longint round_shift(longint v, int sh);
			return (v + (longint'(1) << (sh - 1))) >>> sh;
		endfunction

		function longint round_div(longint num, longint den);
			longint t, d2;
			t = 2 * num + den;
			d2 = 2 * den;
			if (t >= 0) return t / d2;
			return -((-t + d2 - 1) / d2);
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] v);
			case (idx)
				REG_DRY_GAIN:      dry = longint'(v);
				REG_WET_GAIN:      wet = longint'(v);
				REG_FEEDBACK_GAIN: fbg = longint'(v[14:0]);
				REG_AVERAGE_MODE:  avg = v[0];
				default: ;
			endcase
		endfunction

		function void note_item(req_t r);
			longint xin[NCH], bufv[NCH], h[NCH], rd[NCH], mix[NCH];
			longint sum, corr, hh, g, sl, sr, a, b, lo, ro, v;
			int idx, t, len;
			rsp_t e;
			if (r.func == FUNC_LOAD) begin
				idx = int'(r.tap_index);
				if (idx < NTAPS) begin
					tap_off[idx] = int'(r.tap_delay);
					if (idx < NDIFF) flip[idx] = r.tap_flip;
				end
				e = '0;
				expected_q.push_back(e);
				return;
			end
			for (int ch = 0; ch < NCH; ch++) begin
				xin[ch] = (ch % 2) ? longint'(r.right_in) : longint'(r.left_in);
				bufv[ch] = xin[ch];
			end
			for (int d = 0; d < NSTG; d++) begin
				for (int ch = 0; ch < NCH; ch++)
					dline[d * NCH + ch][dhead] = int'(bufv[ch]);
				for (int ch = 0; ch < NCH; ch++) begin
					t = (dhead + DEPTH - (tap_off[d * NCH + ch] % DEPTH)) % DEPTH;
					h[ch] = dline[d * NCH + ch][t];
				end
				for (len = 1; len < NCH; len *= 2)
					for (int i = 0; i < NCH; i += 2 * len)
						for (int j = 0; j < len; j++) begin
							a = h[i + j];
							b = h[i + j + len];
							h[i + j] = a + b;
							h[i + j + len] = a - b;
						end
				for (int ch = 0; ch < NCH; ch++) begin
					v = clip24(round_shift(h[ch] * hscale, 20));
					if (flip[d * NCH + ch]) v = clip24(-v);
					bufv[ch] = v;
				end
			end
			dhead = (dhead + 1) % DEPTH;
			sum = 0;
			for (int ch = 0; ch < NCH; ch++) begin
				t = (fhead + DEPTH - (tap_off[NDIFF + ch] % DEPTH)) % DEPTH;
				rd[ch] = fline[ch][t];
				sum += rd[ch];
			end
			corr = round_div(-2 * sum, NCH);
			for (int ch = 0; ch < NCH; ch++) begin
				hh = clip24(rd[ch] + corr);
				g = clip24(round_shift(hh * fbg, 14));
				fline[ch][fhead] = int'(clip24(bufv[ch] + g));
			end
			fhead = (fhead + 1) % DEPTH;
			for (int ch = 0; ch < NCH; ch++)
				mix[ch] = clip24(round_shift(xin[ch] * dry + rd[ch] * wet, 14));
			if (avg) begin
				sl = 0;
				sr = 0;
				for (int ch = 0; ch < NCH; ch += 2) begin
					sl += mix[ch];
					if (ch + 1 < NCH) sr += mix[ch + 1];
				end
				lo = clip24(round_div(2 * sl, NCH));
				ro = clip24(round_div(2 * sr, NCH));
			end else begin
				lo = mix[0];
				ro = mix[1];
			end
			e.left_out = lo[23:0];
			e.right_out = ro[23:0];
			expected_q.push_back(e);
		endfunction

		task report(string what, logic [23:0] got, logic [23:0] want);
			errors++;
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		endtask

		task check_beat(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				report("unexpected beat", got.left_out, 24'h0);
				return;
			end
			e = expected_q.pop_front();
			if (got.left_out !== e.left_out) report("left_out", got.left_out, e.left_out);
			if (got.right_out !== e.right_out) report("right_out", got.right_out, e.right_out);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_we;
	reg_idx_t    cfg_index;
	logic [15:0] cfg_wdata;

	reverb_scoreboard sb;
	int burst_left;
	int stall_mode;
	int stall_timer;
	int idle_cycles;

	fdn_reverb_diffused u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 0;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		rsp_stall = 0;
		cfg_we = 0;
		cfg_index = REG_DRY_GAIN;
		cfg_wdata = '0;
		burst_left = 0;
		stall_mode = 0;
		stall_timer = 0;
		idle_cycles = 0;
		sb = new();
	end

	always #5 clk = ~clk;

	// Receiver stall pattern: switch between free flow, light and heavy stalling.
	always @(posedge clk) begin
		if (stall_timer == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_timer <= $urandom_range(50, 400);
		end else begin
			stall_timer <= stall_timer - 1;
		end
		case (stall_mode)
			1:       rsp_stall <= ($urandom_range(0, 3) == 0);
			2:       rsp_stall <= ($urandom_range(0, 15) != 0);
			default: rsp_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) sb.check_beat(rsp);
			if (req_valid && !req_stall) sb.note_item(req);
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_MAX) begin
				$display("[fdn_reverb_diffused] ERROR");
				$finish;
			end
		end
	end

	task automatic send(req_t r);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		burst_left--;
	endtask

	task automatic send_load(int idx, int dly, bit fl);
		req_t r;
		r = '0;
		r.func = FUNC_LOAD;
		r.tap_index = 6'(idx);
		r.tap_delay = 13'(dly);
		r.tap_flip = fl;
		r.left_in = 24'($urandom);
		r.right_in = 24'($urandom);
		send(r);
	endtask

	task automatic send_sample(logic [23:0] lv, logic [23:0] rv);
		req_t r;
		r = '0;
		r.func = FUNC_PROCESS;
		r.left_in = lv;
		r.right_in = rv;
		r.tap_index = 6'($urandom);
		r.tap_delay = 13'($urandom);
		r.tap_flip = 1'($urandom);
		send(r);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// Drop valid and let every outstanding beat drain before touching registers.
	task automatic drain();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(0, 5))
			0:       return 24'h7FFFFF;
			1:       return 24'h800000;
			2:       return 24'($signed($urandom_range(0, 2047)) - 1024);
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] dry_v, wet_v, fb_v, avg_v;
		int dly;
		#0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_reg(REG_DRY_GAIN, 16'd16384);
		write_reg(REG_WET_GAIN, 16'd4096);
		write_reg(REG_FEEDBACK_GAIN, 16'd11600);
		write_reg(REG_AVERAGE_MODE, 16'd0);

		// All taps before any sample: zero, short and longest delays, mixed flips.
		for (int i = 0; i < NTAPS; i++) begin
			if (i == 3 || i == NDIFF + 2) dly = 0;
			else if (i == 5) dly = 8191;
			else dly = (i < NDIFF) ? (i % 7) + 1 : (i % 5) + 2;
			send_load(i, dly, (i % 3) == 0 || i >= NDIFF);
		end
		send_load(NTAPS, 8191, 1'b1);
		send_load(63, 8191, 1'b1);
		send_sample(24'h000000, 24'h000000);
		send_sample(24'h7FFFFF, 24'h7FFFFF);
		send_sample(24'h800000, 24'h800000);
		send_sample(24'h7FFFFF, 24'h800000);
		send_sample(24'h800000, 24'h7FFFFF);
		for (int i = 0; i < 6; i++) send_sample(rand_sample(), rand_sample());

		for (int ph = 0; ph < 7; ph++) begin
			drain();
			case (ph)
				0: begin
					dry_v = 16'd65535; wet_v = 16'd65535; fb_v = 16'd16384; avg_v = 16'd1;
				end
				1: begin
					dry_v = 16'd0; wet_v = 16'd65535; fb_v = 16'd16384; avg_v = 16'd0;
				end
				2: begin
					dry_v = 16'd65535; wet_v = 16'd0; fb_v = 16'd0; avg_v = 16'd1;
				end
				3: begin
					dry_v = 16'd0; wet_v = 16'd0; fb_v = 16'd8000; avg_v = 16'd0;
				end
				4: begin
					dry_v = 16'd16384; wet_v = 16'd4096; fb_v = 16'd11600; avg_v = 16'd1;
				end
				default: begin
					dry_v = 16'($urandom);
					wet_v = 16'($urandom);
					fb_v = 16'($urandom_range(0, 16384));
					avg_v = 16'($urandom_range(0, 1));
				end
			endcase
			write_reg(REG_DRY_GAIN, dry_v);
			write_reg(REG_WET_GAIN, wet_v);
			write_reg(REG_FEEDBACK_GAIN, fb_v);
			write_reg(REG_AVERAGE_MODE, avg_v);
			for (int n = 0; n < 200; n++) begin
				if ($urandom_range(0, 4) == 0) begin
					dly = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom;
					send_load($urandom_range(0, 63), dly, 1'($urandom_range(0, 1)));
				end else begin
					send_sample(rand_sample(), rand_sample());
				end
			end
		end

		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("[fdn_reverb_diffused] OK");
		end else begin
			$display("[fdn_reverb_diffused] ERROR");
		end
		$finish;
	end

endmodule
